### design/binary_image_centroid_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef BINARY_IMAGE_CENTROID_UNIT_ASSERT_SVH
`define BINARY_IMAGE_CENTROID_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define BIC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define BIC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bic_pkg.sv
package bic_pkg;

   // Size registers and config port
   localparam int CFG_W       = 11;
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

   // Stream payloads
   localparam int PIXEL_W     = 8;
   localparam int CTR_W       = 11;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * CTR_W;

endpackage

### design/bic_front.sv
// Front end: raster position tracking and moment accumulation per pixel.
module bic_front import bic_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT),
   parameter int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
   parameter int CSUM_W     = CNT_W + COL_W,
   parameter int RSUM_W     = CNT_W + ROW_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [PIXEL_W-1:0] pixel,
   input  logic [CFG_W-1:0]   frame_width,
   input  logic [CFG_W-1:0]   frame_height,
   output logic               push,
   output logic [CNT_W-1:0]   push_count,
   output logic [CSUM_W-1:0]  push_col_sum,
   output logic [RSUM_W-1:0]  push_row_sum
);

   localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
   localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_next;
   logic [CSUM_W-1:0] csum_ff, csum_in, csum_next;
   logic [RSUM_W-1:0] rsum_ff, rsum_in, rsum_next;
   logic [WEFF_W-1:0] w_eff;
   logic [HEFF_W-1:0] h_eff;
   logic              is_obj, row_end, frame_end;

   // Effective frame size: zero counts as one, large values saturate
   always_comb begin
      if (frame_width == '0) begin
         w_eff = WEFF_W'(1);
      end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(frame_width);
      end
      if (frame_height == '0) begin
         h_eff = HEFF_W'(1);
      end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
         h_eff = HEFF_W'(MAX_HEIGHT);
      end else begin
         h_eff = HEFF_W'(frame_height);
      end
   end

   // Row / frame end detect
   assign is_obj    = (pixel != '0);
   assign row_end   = (WEFF_W'(col_ff) + WEFF_W'(1)) >= w_eff;
   assign frame_end = row_end && ((HEFF_W'(row_ff) + HEFF_W'(1)) >= h_eff);

   // Moments including the current pixel
   assign cnt_next  = cnt_ff + CNT_W'(is_obj);
   assign csum_next = csum_ff + (is_obj ? CSUM_W'(col_ff) : '0);
   assign rsum_next = rsum_ff + (is_obj ? RSUM_W'(row_ff) : '0);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cnt_in  = cnt_ff;
      csum_in = csum_ff;
      rsum_in = rsum_ff;
      if (accept) begin
         if (frame_end) begin
            col_in  = '0;
            row_in  = '0;
            cnt_in  = '0;
            csum_in = '0;
            rsum_in = '0;
         end else begin
            cnt_in  = cnt_next;
            csum_in = csum_next;
            rsum_in = rsum_next;
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cnt_ff  <= '0;
         csum_ff <= '0;
         rsum_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cnt_ff  <= cnt_in;
         csum_ff <= csum_in;
         rsum_ff <= rsum_in;
      end
   end

   // Frame totals go to the queue on the last pixel
   assign push         = accept && frame_end;
   assign push_count   = cnt_next;
   assign push_col_sum = csum_next;
   assign push_row_sum = rsum_next;

endmodule

### design/bic_fifo.sv
// Two-entry queue of frame totals between front and divider.
module bic_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/bic_divide.sv
// Back end: two restoring dividers (column and row) in lockstep, one quotient
// bit per cycle each, then a result register held until taken.
module bic_divide import bic_pkg::*; #(
   parameter int CNT_W = 21,
   parameter int DIV_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  logic [CNT_W-1:0] job_count,
   input  logic [DIV_W-1:0] job_col_sum,
   input  logic [DIV_W-1:0] job_row_sum,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CTR_W-1:0] center_x,
   output logic [CTR_W-1:0] center_y,
   output logic             found
);

   localparam int STEP_W = $clog2(DIV_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [CNT_W-1:0]  remx_ff, remx_in, remy_ff, remy_in;
   logic [CTR_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic              found_ff, found_in;
   logic [CNT_W:0]    trial_x, trial_y, diff_x, diff_y;
   logic              bit_x, bit_y;
   logic [DIV_W-1:0]  qx_step, qy_step;
   logic [CNT_W-1:0]  remx_step, remy_step;

   // One restoring step on each divider; no borrow means the divisor fits
   always_comb begin
      trial_x   = {remx_ff, qx_ff[DIV_W-1]};
      trial_y   = {remy_ff, qy_ff[DIV_W-1]};
      diff_x    = trial_x - {1'b0, divisor_ff};
      diff_y    = trial_y - {1'b0, divisor_ff};
      bit_x     = !diff_x[CNT_W];
      bit_y     = !diff_y[CNT_W];
      remx_step = bit_x ? diff_x[CNT_W-1:0] : trial_x[CNT_W-1:0];
      remy_step = bit_y ? diff_y[CNT_W-1:0] : trial_y[CNT_W-1:0];
      qx_step   = {qx_ff[DIV_W-2:0], bit_x};
      qy_step   = {qy_ff[DIV_W-2:0], bit_y};
   end

   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      remx_in    = remx_ff;
      remy_in    = remy_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      found_in   = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               divisor_in = job_count;
               qx_in      = job_col_sum;
               qy_in      = job_row_sum;
               remx_in    = '0;
               remy_in    = '0;
               step_in    = STEP_W'(DIV_W - 1);
               if (job_count == '0) begin
                  // empty frame: no object pixels
                  cx_in    = '1;
                  cy_in    = '1;
                  found_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            qx_in   = qx_step;
            qy_in   = qy_step;
            remx_in = remx_step;
            remy_in = remy_step;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               cx_in    = CTR_W'(qx_step);
               cy_in    = CTR_W'(qy_step);
               found_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      remx_ff    <= remx_in;
      remy_ff    <= remy_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      found_ff   <= found_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign center_x  = cx_ff;
   assign center_y  = cy_ff;
   assign found     = found_ff;

endmodule

### design/binary_image_centroid_unit.sv
// Channel  Dir  Payload                                     Handshake
// req_     in   tdata: pixel[7:0]                           tvalid/tready
// rsp_     out  tdata: center_x, center_y, pad; tuser:found tvalid/tready
// csr_     in   index 0 frame_width, 1 frame_height         valid/ready
//
// Pixels are taken one per cycle; req_tready drops only while both queue
// entries hold frame totals waiting for the divider.
// rsp_tvalid rises once the divider has worked through a frame's totals taken from
// the queue; an empty frame skips the division and goes straight to the result.
// The divider takes a new frame only after the previous result has been taken.
// Reset is synchronous and active high; it clears position, sums, queue and
// restores the size registers to 640 x 480. A stalled rsp_ holds its word.
module binary_image_centroid_unit import bic_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [10:0] center_x, [21:11] center_y, pad
   output logic                   rsp_tuser,   // [0] found
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int CSUM_W = CNT_W + COL_W;
   localparam int RSUM_W = CNT_W + ROW_W;
   localparam int DIV_W  = (CSUM_W > RSUM_W) ? CSUM_W : RSUM_W;
   localparam int Q_W    = CNT_W + CSUM_W + RSUM_W;

   logic [CFG_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic              accept, push, pop, q_full, q_not_empty;
   logic [CNT_W-1:0]  push_count;
   logic [CSUM_W-1:0] push_col_sum;
   logic [RSUM_W-1:0] push_row_sum;
   logic [Q_W-1:0]    q_rd_data;
   logic [CTR_W-1:0]  center_x, center_y;

   // Size registers
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   bic_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W),
      .CNT_W      (CNT_W),
      .CSUM_W     (CSUM_W),
      .RSUM_W     (RSUM_W)
   ) front_inst (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel        (req_tdata),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .push         (push),
      .push_count   (push_count),
      .push_col_sum (push_col_sum),
      .push_row_sum (push_row_sum)
   );

   bic_fifo #(
      .DATA_W (Q_W)
   ) queue_inst (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_row_sum, push_col_sum, push_count}),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_rd_data)
   );

   bic_divide #(
      .CNT_W (CNT_W),
      .DIV_W (DIV_W)
   ) divide_inst (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (q_not_empty),
      .job_count   (q_rd_data[CNT_W-1:0]),
      .job_col_sum (DIV_W'(q_rd_data[CNT_W+CSUM_W-1:CNT_W])),
      .job_row_sum (DIV_W'(q_rd_data[Q_W-1:CNT_W+CSUM_W])),
      .job_pop     (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .center_x    (center_x),
      .center_y    (center_y),
      .found       (rsp_tuser)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), center_y, center_x};

endmodule

### design/bic_checker.sv
`include "binary_image_centroid_unit_assert.svh"

// Port-level checks on the centroid unit.
module bic_checker import bic_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // stalled result word holds
   `BIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed under stall")

   // empty frame reports minus one on both axes
   `BIC_ASSERT_SAME(a_empty_frame, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[2*CTR_W-1:0] == '1, "empty frame without -1 centroid")

   // padding above the coordinates stays zero
   `BIC_ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_TDATA_W-1:2*CTR_W] == '0, "rsp pad bits nonzero")

   // no result right after reset
   `BIC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "rsp_tvalid after reset")

endmodule

bind binary_image_centroid_unit bic_checker checker_inst (.*);

### tb/sv/binary_image_centroid_unit_tb.sv
package binary_image_centroid_tb_pkg;
   import bic_pkg::*;

   // One centroid word as it leaves the block
   typedef struct packed {
      logic signed [CTR_W-1:0] center_x;
      logic signed [CTR_W-1:0] center_y;
      logic                    found;
   } centroid_type;

   // Tracks frame position and moment sums, queues the centroid of each finished frame
   class centroid_tracker;
      int unsigned      max_width;
      int unsigned      max_height;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic [9:0]       column;
      logic [9:0]       row;
      logic [20:0]      object_count;
      logic [30:0]      column_sum;
      logic [30:0]      row_sum;
      centroid_type     pending_centroids[$];
      int unsigned      mismatches;

      function new(int unsigned max_w, int unsigned max_h);
         max_width    = max_w;
         max_height   = max_h;
         width_reg    = FRAME_WIDTH_RESET;
         height_reg   = FRAME_HEIGHT_RESET;
         column       = '0;
         row          = '0;
         object_count = '0;
         column_sum   = '0;
         row_sum      = '0;
         mismatches   = 0;
      endfunction

      // zero counts as one, oversize saturates at the bound
      function int unsigned effective_size(logic [CFG_W-1:0] raw, int unsigned bound);
         if (raw == '0) return 1;
         if (32'(raw) > bound) return bound;
         return 32'(raw);
      endfunction

      function void note_register(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
         if (index == CSR_FRAME_WIDTH) width_reg = data;
         else if (index == CSR_FRAME_HEIGHT) height_reg = data;
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] pixel);
         int unsigned  w;
         int unsigned  h;
         bit           row_end;
         bit           frame_end;
         centroid_type c;
         w         = effective_size(width_reg, max_width);
         h         = effective_size(height_reg, max_height);
         row_end   = (32'(column) + 1) >= w;
         frame_end = row_end && ((32'(row) + 1) >= h);
         if (pixel != '0) begin
            object_count += 1;
            column_sum   += 31'(column);
            row_sum      += 31'(row);
         end
         if (frame_end) begin
            if (object_count != '0) begin
               c.center_x = CTR_W'(column_sum / 31'(object_count));
               c.center_y = CTR_W'(row_sum / 31'(object_count));
               c.found    = 1'b1;
            end else begin
               c.center_x = '1;
               c.center_y = '1;
               c.found    = 1'b0;
            end
            pending_centroids.push_back(c);
            column       = '0;
            row          = '0;
            object_count = '0;
            column_sum   = '0;
            row_sum      = '0;
         end else if (row_end) begin
            column = '0;
            row    = row + 1;
         end else begin
            column = column + 1;
         end
      endfunction

      function void check_centroid(logic [RSP_TDATA_W-1:0] data, logic user);
         centroid_type want;
         centroid_type got;
         got.center_x = data[CTR_W-1:0];
         got.center_y = data[2*CTR_W-1:CTR_W];
         got.found    = user;
         if (pending_centroids.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected centroid word: x=%0d y=%0d found=%0b",
                        got.center_x, got.center_y, got.found);
            return;
         end
         want = pending_centroids.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("centroid mismatch: exp x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
                        want.center_x, want.center_y, want.found,
                        got.center_x, got.center_y, got.found);
         end
      endfunction

      function int unsigned outstanding();
         return pending_centroids.size();
      endfunction
   endclass
endpackage

module binary_image_centroid_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bic_pkg::*;
   import binary_image_centroid_tb_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 1024;
   localparam int IDLE_PCT      = 19;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int ITEM_TARGET   = 560;
   localparam int STEADY_ITEMS  = 250;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_INDEX_W'(5);

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;

   centroid_tracker tracker = new(MAX_W, MAX_H);
   bit              steady = 1'b0;
   bit              hold_request = 1'b0;
   int unsigned     cycle_count = 0;

   binary_image_centroid_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: check accepted words, then pick next tready
   initial begin : rsp_side
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tracker.check_centroid(rsp_tdata, rsp_tuser);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      tracker.note_pixel(pixel);
   endtask

   // csr_valid stays up across back-to-back writes, drops after the last
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CFG_W-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.note_register(index, data);
      if (last) csr_valid <= 1'b0;
   endtask

   // drain every pending centroid, then let the divider go quiet
   task automatic wait_idle();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] object_pixel(int unsigned density);
      if ($urandom_range(0, 99) < density) return PIXEL_W'($urandom_range(1, 255));
      return '0;
   endfunction

   function automatic int unsigned pick_density();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 5;
         2: return 30;
         3: return 70;
         default: return 100;
      endcase
   endfunction

   initial begin : stimulus
      int unsigned random_items;
      int unsigned w;
      int unsigned h;
      int unsigned frame_pixels;
      int unsigned frames;
      int unsigned density;
      logic [CFG_W-1:0] w_raw;
      logic [CFG_W-1:0] h_raw;
      random_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // 1x1 frames: empty frame and pixel extremes
      write_reg(CSR_FRAME_WIDTH, CFG_W'(1), 1'b0);
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(1), 1'b1);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd1);
      send_pixel(8'd128);
      req_tvalid <= 1'b0;
      wait_idle();

      // 3x2: empty frame, lone object in the last corner, then a partial frame
      write_reg(CSR_FRAME_WIDTH, CFG_W'(3), 1'b0);
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(2), 1'b1);
      repeat (6) send_pixel(8'd0);
      repeat (5) send_pixel(8'd0);
      send_pixel(8'h80);
      send_pixel(8'd0);
      send_pixel(8'd0);
      req_tvalid <= 1'b0;
      wait_idle();

      // shrink width to zero (acts as one) while column sits past it; unmapped write ignored
      write_reg(CSR_FRAME_WIDTH, CFG_W'(0), 1'b0);
      write_reg(CSR_UNMAPPED, CFG_W'(2047), 1'b1);
      send_pixel(8'd1);
      send_pixel(8'd255);
      req_tvalid <= 1'b0;
      wait_idle();

      // receiver holds off while 1x1 frames keep coming, so the block backs up
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(1), 1'b1);
      hold_request = 1'b1;
      repeat (24) send_pixel(object_pixel(50));
      req_tvalid <= 1'b0;
      wait_idle();

      // random phases of small frames, sometimes cut mid-frame before the next size change
      while (random_items < ITEM_TARGET) begin
         steady = (random_items < STEADY_ITEMS);
         case ($urandom_range(0, 99)) inside
            [0:2]: begin
               w = $urandom_range(100, 300);
               h = 1;
            end
            [3:19]: begin
               w = $urandom_range(7, 32);
               h = $urandom_range(1, 3);
            end
            default: begin
               w = $urandom_range(1, 6);
               h = $urandom_range(1, 6);
            end
         endcase
         w_raw = CFG_W'(w);
         h_raw = CFG_W'(h);
         if (w == 1 && $urandom_range(0, 3) == 0) w_raw = '0;
         if (h == 1 && $urandom_range(0, 3) == 0) h_raw = '0;
         if ($urandom_range(0, 9) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(2, 255)), CFG_W'($urandom_range(0, 2047)), 1'b0);
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_FRAME_WIDTH, w_raw, 1'b0);
            write_reg(CSR_FRAME_HEIGHT, h_raw, 1'b1);
         end else begin
            write_reg(CSR_FRAME_HEIGHT, h_raw, 1'b0);
            write_reg(CSR_FRAME_WIDTH, w_raw, 1'b1);
         end
         frame_pixels = w * h;
         frames = (frame_pixels > 64) ? 1 : $urandom_range(1, 4);
         repeat (frames) begin
            density = pick_density();
            repeat (frame_pixels) send_pixel(object_pixel(density));
            random_items += frame_pixels;
         end
         if (frame_pixels > 1 && $urandom_range(0, 99) < 30) begin
            density = pick_density();
            frames  = $urandom_range(1, frame_pixels - 1);
            repeat (frames) send_pixel(object_pixel(density));
            random_items += frames;
         end
         req_tvalid <= 1'b0;
         wait_idle();
      end
      steady = 1'b0;

      // widest row via saturated width: lone object at the last column
      write_reg(CSR_FRAME_WIDTH, CFG_W'(2047), 1'b0);
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(0), 1'b1);
      for (int i = 0; i < MAX_W; i++)
         send_pixel((i == MAX_W - 1) ? 8'hFF : 8'h00);
      req_tvalid <= 1'b0;
      wait_idle();

      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
